@@ rtl/pnd_pkg.sv @@
// ----------------------------------------------------------------------------
// pnd_pkg
// shared widths, constants, candidate type and compare rule for the pll
// n/m divider search pipeline
// ----------------------------------------------------------------------------
package pnd_pkg;

    // search depth: post divider runs from this value down to 1
    localparam int unsigned MAX_DIVIDER = 15;

    localparam int unsigned REQ_W   = 20;
    localparam int unsigned N_W     = 7;
    localparam int unsigned M_W     = 4;
    localparam int unsigned ERR_W   = 20;
    localparam int unsigned PROD_W  = 24;
    localparam int unsigned N0_W    = 13;
    localparam int unsigned VAL_X_W = 20;
    localparam int unsigned RECIP_W = 25;

    localparam int unsigned REF_BASE_KHZ   = 3000;
    localparam int unsigned REF_DOUBLE_KHZ = 6000;
    localparam int unsigned REQ_MIN_KHZ    = 20000;
    localparam int unsigned REQ_MAX_KHZ    = 400000;
    localparam int unsigned N_BASE_MIN     = 10;
    localparam int unsigned N_DOUBLE_MIN   = 64;
    localparam int unsigned N_MAX          = 127;

    // floor(x / 3000) as (x * recip) >> shift, exact for x below 2^23
    localparam int unsigned DIV3K_SHIFT = 35;
    localparam logic [PROD_W-1:0] DIV3K_RECIP =
        PROD_W'(((64'd1 << DIV3K_SHIFT) + 64'(REF_BASE_KHZ) - 64'd1) / 64'(REF_BASE_KHZ));

    // floor(x / m) as (x * recip) >> shift, exact for x below 2^20 and m up to 15
    localparam int unsigned VAL_SHIFT = 24;

    // candidate slots within one divider lane, in visiting order
    localparam int unsigned SLOT_BASE_LO = 0;
    localparam int unsigned SLOT_BASE_HI = 1;
    localparam int unsigned SLOT_DBL_LO  = 2;
    localparam int unsigned SLOT_DBL_HI  = 3;
    localparam int unsigned SLOTS        = 4;

    localparam int unsigned NUM_CAND     = SLOTS * MAX_DIVIDER;
    localparam int unsigned TREE_LEVELS  = $clog2(NUM_CAND);
    localparam int unsigned TREE_LEAVES  = 1 << TREE_LEVELS;
    localparam int unsigned FRONT_STAGES = 5;
    localparam int unsigned PIPE_STAGES  = FRONT_STAGES + TREE_LEVELS;

    typedef struct packed {
        logic             valid;
        logic [ERR_W-1:0] err;
        logic [N_W-1:0]   n;
        logic [M_W-1:0]   m;
        logic             dbl;
    } cand_t;

    // earlier a wins ties; valid b wins if a is invalid or its err is lower
    function automatic cand_t pick_cand(cand_t a, cand_t b);
        cand_t r;
        r = a;
        if (b.valid && (!a.valid || (b.err < a.err))) begin
            r = b;
        end
        return r;
    endfunction

endpackage

@@ rtl/pnd_cand_tree.sv @@
// ----------------------------------------------------------------------------
// pnd_cand_tree
// registered minimum tree over all candidates, one level per stage,
// left subtree always holds the earlier candidates
// ----------------------------------------------------------------------------
module pnd_cand_tree
    import pnd_pkg::*;
(
    input  logic                   aclk,
    input  logic [TREE_LEVELS-1:0] level_en,
    input  cand_t                  leaf_in [NUM_CAND],
    output cand_t                  best_out
);

    cand_t leaf [TREE_LEAVES];
    cand_t node_reg [TREE_LEAVES-1];

    genvar k, i;

    // pad unused leaves with empty candidates
    for (k = 0; k < TREE_LEAVES; k++) begin : g_leaf
        if (k < NUM_CAND) begin : g_used
            assign leaf[k] = leaf_in[k];
        end else begin : g_pad
            assign leaf[k] = '0;
        end
    end

    // heap layout: node i has children 2i+1 and 2i+2
    for (i = 0; i < TREE_LEAVES - 1; i++) begin : g_node
        localparam int unsigned DEPTH = $clog2(i + 2) - 1;
        localparam int unsigned STG   = TREE_LEVELS - 1 - DEPTH;
        localparam int unsigned LC    = 2 * i + 1;
        localparam int unsigned RC    = 2 * i + 2;

        cand_t left_c;
        cand_t right_c;

        if (LC >= TREE_LEAVES - 1) begin : g_from_leaf
            assign left_c  = leaf[LC - (TREE_LEAVES - 1)];
            assign right_c = leaf[RC - (TREE_LEAVES - 1)];
        end else begin : g_from_node
            assign left_c  = node_reg[LC];
            assign right_c = node_reg[RC];
        end

        always_ff @(posedge aclk) begin
            if (level_en[STG]) begin
                node_reg[i] <= pick_cand(left_c, right_c);
            end
        end
    end

    assign best_out = node_reg[0];

endmodule

@@ rtl/pll_n_m_divider_search.sv @@
// ----------------------------------------------------------------------------
// pll_n_m_divider_search
// picks pll multiplier n, post divider m and doubler choice whose truncated
// output frequency lies nearest to a requested dot clock
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake                 payload
//  s_       in   s_tvalid / s_tready       s_tdata[19:0] requested_khz
//  m_       out  m_tvalid / m_tready       m_tdata n, m, doubler; m_tuser range error
//
//  one transfer in and one out per cycle when the output side keeps up
//  five stages of per-divider lanes, then a compare tree with one level a stage
//  reset clears the stage valid bits only; payload registers are not reset
//  each stage holds while the one after it is full and stalled, so empty
//  stages still fill during an output stall and nothing is dropped or repeated
//
module pll_n_m_divider_search
    import pnd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [19:0] requested_khz, [23:20] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] multiplier_n, [10:7] divider_m,
                                   // [11] doubler_on, [15:12] zero
    output logic        m_tuser    // [0] range_error
);

    // pipeline control
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] stage_en;
    logic [PIPE_STAGES-1:0] rerr_reg;

    // request copies travelling with the lanes
    logic [REQ_W-1:0] f0_reg, f1_reg, f2_reg, f3_reg;
    logic [REQ_W-1:0] s_req;

    // leaf candidates, lane g slot j at index g*SLOTS+j
    cand_t cand_reg [NUM_CAND];
    cand_t best;

    genvar g, j, p;

    assign s_req = s_tdata[REQ_W-1:0];

    // a stage may load when it is empty or everything after it can move
    for (p = 0; p < PIPE_STAGES; p++) begin : g_en
        assign stage_en[p] = m_tready | ~(&valid_reg[PIPE_STAGES-1:p]);
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[PIPE_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int unsigned s = 0; s < PIPE_STAGES; s++) begin
                if (stage_en[s]) begin
                    if (s == 0) begin
                        valid_reg[s] <= s_tvalid;
                    end else begin
                        valid_reg[s] <= valid_reg[s-1];
                    end
                end
            end
        end
    end

    // range flag runs the whole pipe, request value runs the lane stages
    always_ff @(posedge aclk) begin
        for (int unsigned s = 0; s < PIPE_STAGES; s++) begin
            if (stage_en[s]) begin
                if (s == 0) begin
                    rerr_reg[s] <= (s_req < REQ_W'(REQ_MIN_KHZ)) ||
                                   (s_req > REQ_W'(REQ_MAX_KHZ));
                end else begin
                    rerr_reg[s] <= rerr_reg[s-1];
                end
            end
        end
        if (stage_en[0]) f0_reg <= s_req;
        if (stage_en[1]) f1_reg <= f0_reg;
        if (stage_en[2]) f2_reg <= f1_reg;
        if (stage_en[3]) f3_reg <= f2_reg;
    end

    // one lane per post divider, lane 0 holds the largest divider
    for (g = 0; g < MAX_DIVIDER; g++) begin : g_lane
        localparam int unsigned M = MAX_DIVIDER - g;
        localparam logic [M_W-1:0] M_CODE = M_W'(M);
        localparam bit M_ODD = (M % 2) == 1;
        localparam logic [RECIP_W-1:0] VAL_RECIP =
            RECIP_W'(((64'd1 << VAL_SHIFT) + 64'(M) - 64'd1) / 64'(M));

        logic [PROD_W-1:0]  prod_reg;
        logic [N0_W-1:0]    n0_reg;
        logic [N0_W:0]      n_full [SLOTS];
        logic [N_W-1:0]     n2_reg [SLOTS];
        logic [N_W-1:0]     n3_reg [SLOTS];
        logic               ok2_reg [SLOTS];
        logic               ok3_reg [SLOTS];
        logic [VAL_X_W-1:0] x_reg [SLOTS];
        logic [VAL_X_W-1:0] v_reg [SLOTS];

        // stage 0: m * f
        always_ff @(posedge aclk) begin
            if (stage_en[0]) begin
                prod_reg <= PROD_W'(s_req) * PROD_W'(M);
            end
        end

        // stage 1: n0 = floor(m * f / 3000)
        always_ff @(posedge aclk) begin
            if (stage_en[1]) begin
                n0_reg <= N0_W'(((2 * PROD_W)'(prod_reg) * (2 * PROD_W)'(DIV3K_RECIP))
                                >> DIV3K_SHIFT);
            end
        end

        // doubled reference: floor(m * f / 6000) is n0 halved
        always_comb begin
            n_full[SLOT_BASE_LO] = {1'b0, n0_reg};
            n_full[SLOT_BASE_HI] = {1'b0, n0_reg} + 1'b1;
            n_full[SLOT_DBL_LO]  = {2'b00, n0_reg[N0_W-1:1]};
            n_full[SLOT_DBL_HI]  = {2'b00, n0_reg[N0_W-1:1]} + 1'b1;
        end

        for (j = 0; j < SLOTS; j++) begin : g_slot
            localparam bit DBL = (j == SLOT_DBL_LO) || (j == SLOT_DBL_HI);
            localparam int unsigned REF  = DBL ? REF_DOUBLE_KHZ : REF_BASE_KHZ;
            localparam int unsigned NMIN = DBL ? N_DOUBLE_MIN : N_BASE_MIN;
            localparam bit USED = !DBL || M_ODD;

            logic [VAL_X_W+RECIP_W-1:0] v_prod;
            logic [ERR_W-1:0]           err;

            // stage 2: window check and ref * n
            always_ff @(posedge aclk) begin
                if (stage_en[2]) begin
                    ok2_reg[j] <= USED &&
                                  (n_full[j] >= (N0_W + 1)'(NMIN)) &&
                                  (n_full[j] <= (N0_W + 1)'(N_MAX));
                    n2_reg[j]  <= n_full[j][N_W-1:0];
                    x_reg[j]   <= VAL_X_W'(n_full[j][N_W-1:0]) * VAL_X_W'(REF);
                end
            end

            // stage 3: truncated output frequency ref * n / m
            assign v_prod = (VAL_X_W + RECIP_W)'(x_reg[j]) *
                            (VAL_X_W + RECIP_W)'(VAL_RECIP);

            always_ff @(posedge aclk) begin
                if (stage_en[3]) begin
                    v_reg[j]   <= VAL_X_W'(v_prod >> VAL_SHIFT);
                    ok3_reg[j] <= ok2_reg[j];
                    n3_reg[j]  <= n2_reg[j];
                end
            end

            // stage 4: absolute error becomes a tree leaf
            assign err = (v_reg[j] >= f3_reg) ? (v_reg[j] - f3_reg) : (f3_reg - v_reg[j]);

            always_ff @(posedge aclk) begin
                if (stage_en[4]) begin
                    cand_reg[g * SLOTS + j] <= '{valid: ok3_reg[j], err: err,
                                                 n: n3_reg[j], m: M_CODE, dbl: DBL};
                end
            end
        end
    end

    // nearest candidate, earliest one on equal error
    pnd_cand_tree u_tree (
        .aclk     (aclk),
        .level_en (stage_en[PIPE_STAGES-1:FRONT_STAGES]),
        .leaf_in  (cand_reg),
        .best_out (best)
    );

    // out of range or nothing found gives zero fields
    always_comb begin
        m_tdata = '0;
        if (!rerr_reg[PIPE_STAGES-1] && best.valid) begin
            m_tdata[6:0]  = best.n;
            m_tdata[10:7] = best.m;
            m_tdata[11]   = best.dbl;
        end
    end

    assign m_tuser = rerr_reg[PIPE_STAGES-1];

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pll n/m divider search: a directed table of edge
// and tie requests, then about 1700 random requests over four handshake phases,
// each checked against a typed-in result or a local nearest-frequency predictor
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pnd_pkg::*;

    localparam int unsigned ITEMS_PER_PHASE = 425;
    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam int unsigned MAX_REPORTS     = 100;
    localparam int unsigned ERR_START       = 32'h0FFF_FFFF;

    // one decoded result: what the block chose for a request
    typedef struct packed {
        logic [N_W-1:0] n;
        logic [M_W-1:0] m;
        logic           doubler;
        logic           range_error;
    } pll_choice_t;

    typedef struct {
        logic [REQ_W-1:0] khz;
        bit               fixed;   // expectation typed in below
        pll_choice_t      want;
    } directed_row_t;

    localparam pll_choice_t RANGE_FAULT = '{n: '0, m: '0, doubler: 1'b0, range_error: 1'b1};
    localparam pll_choice_t NO_CHOICE   = '0;

    // edges of the request window, exact hits and bit patterns
    directed_row_t directed [23] = '{
        '{20'd0,       1'b1, RANGE_FAULT},
        '{20'd1,       1'b1, RANGE_FAULT},
        '{20'd19999,   1'b1, RANGE_FAULT},
        '{20'd400001,  1'b1, RANGE_FAULT},
        '{20'hFFFFF,   1'b1, RANGE_FAULT},
        '{20'h80000,   1'b1, RANGE_FAULT},
        '{20'd20000,   1'b0, NO_CHOICE},
        '{20'd20001,   1'b0, NO_CHOICE},
        '{20'd400000,  1'b0, NO_CHOICE},
        '{20'd399999,  1'b0, NO_CHOICE},
        '{20'd30000,   1'b0, NO_CHOICE},
        '{20'd25175,   1'b0, NO_CHOICE},
        '{20'd27000,   1'b0, NO_CHOICE},
        '{20'd65000,   1'b0, NO_CHOICE},
        '{20'd74250,   1'b0, NO_CHOICE},
        '{20'd108000,  1'b0, NO_CHOICE},
        '{20'd148500,  1'b0, NO_CHOICE},
        '{20'd200000,  1'b0, NO_CHOICE},
        '{20'd297000,  1'b0, NO_CHOICE},
        '{20'd384000,  1'b0, NO_CHOICE},
        '{20'h5AAAA,   1'b0, NO_CHOICE},
        '{20'h2AAAA,   1'b0, NO_CHOICE},
        '{20'h55555,   1'b0, NO_CHOICE}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [19:0] requested_khz, [23:20] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [6:0] multiplier_n, [10:7] divider_m,
                                  // [11] doubler_on, [15:12] zero
    logic        m_tuser;         // [0] range_error

    // choices still owed by the block, oldest first
    pll_choice_t pending_choices [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches     = 0;
    int unsigned requests_sent  = 0;
    int unsigned out_of_range   = 0;
    int unsigned doubled_picks  = 0;
    logic [15:0] dividers_seen  = '0;
    int unsigned quiet_cycles   = 0;

    pll_n_m_divider_search dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // nearest truncated ref*n/m to the request; base path then doubled path
    // per divider, a later candidate only wins on a strictly smaller error
    function automatic pll_choice_t nearest_pll_setting(input logic [REQ_W-1:0] khz);
        pll_choice_t best;
        int unsigned f, best_err, ref_khz, n_floor, n_low, n, value, err;
        int          m, path, step;
        best = '0;
        f    = 32'(khz);
        if (f < REQ_MIN_KHZ || f > REQ_MAX_KHZ) begin
            best.range_error = 1'b1;
            return best;
        end
        best_err = ERR_START;
        for (m = MAX_DIVIDER; m >= 1; m--) begin
            for (path = 0; path < 2; path++) begin
                // doubled reference only for odd dividers
                if (path == 1 && m % 2 == 0) begin
                    continue;
                end
                ref_khz = (path == 1) ? REF_DOUBLE_KHZ : REF_BASE_KHZ;
                n_low   = (path == 1) ? N_DOUBLE_MIN : N_BASE_MIN;
                n_floor = (m * f) / ref_khz;
                for (step = 0; step < 2; step++) begin
                    n = n_floor + step;
                    if (n >= n_low && n <= N_MAX) begin
                        value = (ref_khz * n) / m;
                        err   = (value >= f) ? value - f : f - value;
                        if (err < best_err) begin
                            best_err     = err;
                            best.n       = n[N_W-1:0];
                            best.m       = m[M_W-1:0];
                            best.doubler = (path == 1);
                        end
                    end
                end
            end
        end
        return best;
    endfunction

    // offer one request, holding valid until the transfer, then log what it owes
    task automatic send_request(input logic [REQ_W-1:0] khz, input bit fixed,
                                input pll_choice_t want);
        pll_choice_t owed;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, khz};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        owed = fixed ? want : nearest_pll_setting(khz);
        pending_choices.push_back(owed);
        requests_sent++;
        if (owed.range_error) begin
            out_of_range++;
        end
        if (owed.doubler) begin
            doubled_picks++;
        end
        dividers_seen[owed.m] = 1'b1;
    endtask

    // sender pauses until the block has handed back everything it owes
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_choices.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // receiver side: stall at the rate of the current phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker: each output transfer against the oldest owed choice
    always @(posedge aclk) begin
        pll_choice_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.n           = m_tdata[6:0];
            got.m           = m_tdata[10:7];
            got.doubler     = m_tdata[11];
            got.range_error = m_tuser;
            if (pending_choices.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected result n=%0d m=%0d dbl=%0b err=%0b",
                             $time, got.n, got.m, got.doubler, got.range_error);
                end
            end else begin
                want = pending_choices.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        if (got.n != want.n) begin
                            $display("%0t: multiplier_n expected %0d actual %0d",
                                     $time, want.n, got.n);
                        end
                        if (got.m != want.m) begin
                            $display("%0t: divider_m expected %0d actual %0d",
                                     $time, want.m, got.m);
                        end
                        if (got.doubler != want.doubler) begin
                            $display("%0t: doubler_on expected %0b actual %0b",
                                     $time, want.doubler, got.doubler);
                        end
                        if (got.range_error != want.range_error) begin
                            $display("%0t: range_error expected %0b actual %0b",
                                     $time, want.range_error, got.range_error);
                        end
                    end
                end
            end
        end
    end

    // watchdog: too long with no transfer on either side ends the run
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        logic [REQ_W-1:0] khz;
        int unsigned      pick, nn, mm, phase, item;
        int unsigned      idle_plan  [4] = '{0, 55, 0, 31};
        int unsigned      stall_plan [4] = '{0, 0, 55, 31};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, back to back with the receiver always ready
        foreach (directed[i]) begin
            send_request(directed[i].khz, directed[i].fixed, directed[i].want);
        end
        drain();

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_plan[phase];
            recv_stall_pct = stall_plan[phase];
            for (item = 0; item < ITEMS_PER_PHASE; item++) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    // anywhere in the legal window
                    khz = REQ_W'($urandom_range(REQ_MAX_KHZ, REQ_MIN_KHZ));
                end else if (pick < 75) begin
                    // truncated ref * n / m values, exact hits where that is a legal candidate
                    nn  = $urandom_range(N_MAX, N_BASE_MIN);
                    mm  = $urandom_range(MAX_DIVIDER, 1);
                    khz = REQ_W'((($urandom_range(1) ? REF_DOUBLE_KHZ : REF_BASE_KHZ) * nn)
                                 / mm);
                end else if (pick < 87) begin
                    // around either edge of the window
                    khz = REQ_W'(($urandom_range(1) ? REQ_MAX_KHZ : REQ_MIN_KHZ)
                                 + $urandom_range(16) - 8);
                end else begin
                    // full field, mostly out of range
                    khz = REQ_W'($urandom_range(20'hFFFFF, 0));
                end
                send_request(khz, 1'b0, NO_CHOICE);
            end
            drain();
        end

        // let any stray output surface before judging
        repeat (4 * PIPE_STAGES) @(posedge aclk);

        $display("covered %0d requests, %0d out of range, %0d settled on the doubled reference",
                 requests_sent, out_of_range, doubled_picks);
        $display("post dividers chosen (bit per value): %b", dividers_seen);
        if (mismatches == 0 && pending_choices.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pnd_pkg.sv
rtl/pnd_cand_tree.sv
rtl/pll_n_m_divider_search.sv
tb/tb.sv
